// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the square_and_sort block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/sqs_pkg.sv =====
// Shared types and constants for the square_and_sort block.
// No dependencies; imported by the controller, datapath and top level.
package sqs_pkg;

  localparam int ValueW  = 16;
  localparam int MagW    = 16;
  localparam int SquareW = 31;

  // controller state, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_INS  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // capture magnitude and last flag of an item
    logic square;  // register mag * mag
    logic insert;  // insert square into the sorted row, or mark drop
    logic shift;   // pop lowest entry after an output item is taken
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_q;    // held item ends the set
    logic fill_one;  // exactly one entry left in the row
  } status_t;

endpackage

// ===== design/square_and_sort.sv =====
// square_and_sort top level: squares a set of signed values, emits them sorted.
// Depends on sqs_pkg, sqs_ctrl, sqs_datapath and assert_macros.svh.
//
//  channel | dir | tdata                 | tlast          | tuser
//  s_*     | in  | [15:0] value (signed) | last of set    | -
//  m_*     | out | [30:0] square         | last of result | [0] overflow
//
// Sequence: each input item is squared into a register, then inserted into
//   a sorted row of CAPACITY cells compared in parallel; the next item is
//   taken in the insert cycle of the one before. After the last item is taken,
//   its square and insert steps run, then the held results follow, one per cycle while m_tready is high.
// Reset: rst, synchronous, clears the controller, fill count and drop flag.
// Stalls: m_tready low holds the current result; no input is taken in the
//   square cycle or while a set is being emitted.
module square_and_sort
  import sqs_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [30:0] square, [31] zero
  output logic        m_tlast,
  output logic [0:0]  m_tuser    // [0] overflow
);

`include "assert_macros.svh"

  cmd_t               cmd;
  status_t            status;
  logic [SquareW-1:0] square;
  logic               last_res;
  logic               overflow;

  sqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sqs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value    (s_tdata),
    .last     (s_tlast),
    .status   (status),
    .square   (square),
    .last_res (last_res),
    .overflow (overflow)
  );

  // results come straight from the lowest cell of the sorted row
  assign m_tdata    = {1'b0, square};
  assign m_tlast    = last_res;
  assign m_tuser[0] = overflow;

  // input is never taken while results are being shown
  `ASSERT_NEVER(a_no_overlap, clk, rst, m_tvalid && s_tready, "input accepted during emission")

  // emitted squares are non-decreasing within a set
  `ASSERT_AT(a_sorted, clk, rst,
    (m_tvalid && m_tready && !m_tlast) |=> (m_tdata[30:0] >= $past(m_tdata[30:0])),
    "results out of order")

  // overflow flag is constant across one emitted set
  `ASSERT_AT(a_ovf_steady, clk, rst,
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && (m_tuser == $past(m_tuser))),
    "overflow changed inside a set")

endmodule

// ===== design/sqs_ctrl.sv =====
// Controller FSM for square_and_sort: load, square, insert, emit sequencing.
// Depends on sqs_pkg.
module sqs_ctrl
  import sqs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.square = 1'b1;
        state_next = ST_INS;
      end
      ST_INS: begin
        cmd.insert = 1'b1;
        in_ready   = !status.last_q;
        if (status.last_q) begin
          state_next = ST_EMIT;
        end else if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift = 1'b1;
          if (status.fill_one) state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/sqs_datapath.sv =====
// Datapath for square_and_sort: magnitude, squarer and sorted insertion row.
// Depends on sqs_pkg; driven by sqs_ctrl commands.
module sqs_datapath
  import sqs_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic signed [ValueW-1:0] value,
  input  logic                     last,
  output status_t                  status,
  output logic [SquareW-1:0]       square,
  output logic                     last_res,
  output logic                     overflow
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [MagW-1:0]    mag;
  logic [2*MagW-1:0]  prod;
  logic [SquareW-1:0] sq;
  logic               last_q;
  logic [CntW-1:0]    fill;
  logic               dropped;
  logic [SquareW-1:0] row [CAPACITY];
  logic [CAPACITY-1:0] big;
  logic               full;

  assign full = (fill == CntW'(CAPACITY));

  // full-width product; 0x8000 squared needs bit 30
  assign prod = mag * mag;

  // capture |value|; -32768 gives 0x8000
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag    <= value[ValueW-1] ? MagW'(~value + 1'b1) : MagW'(value);
      last_q <= last;
    end
    if (cmd.square) begin
      sq <= prod[SquareW-1:0];
    end
  end

  // entries above the insert point (row is sorted below fill)
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      big[i] = (CntW'(i) < fill) && (row[i] > sq);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_row
    always_ff @(posedge clk) begin
      if (cmd.insert && !full) begin
        if (big[g] || (CntW'(g) == fill)) begin
          if (g > 0 && big[(g > 0) ? g - 1 : 0]) begin
            row[g] <= row[(g > 0) ? g - 1 : 0];
          end else begin
            row[g] <= sq;
          end
        end
      end else if (cmd.shift && g < CAPACITY - 1) begin
        row[g] <= row[(g < CAPACITY - 1) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.insert) begin
        if (full) dropped <= 1'b1;
        else      fill    <= fill + 1'b1;
      end else if (cmd.shift) begin
        fill <= fill - 1'b1;
        if (fill == CntW'(1)) dropped <= 1'b0;
      end
    end
  end

  assign status.last_q   = last_q;
  assign status.fill_one = (fill == CntW'(1));
  assign square          = row[0];
  assign last_res        = status.fill_one;
  assign overflow        = dropped;

endmodule

// ===== tb/square_and_sort_tb.sv =====
// Self-checking bench for square_and_sort: random sets of signed values in, sorted squares out.
// Depends on sqs_pkg and the square_and_sort RTL; holds its own sorted-row model of the block.
`timescale 1ns / 100ps

module square_and_sort_tb
  import sqs_pkg::*;
();

  localparam int CAP = 64;
  localparam int STALL_LIMIT = 4000;  // cycles with no item taken on either side
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off, once per idling mode

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
  } set_item_t;

  typedef struct packed {
    logic [SquareW-1:0] square;
    logic               last;
    logic               overflow;
  } sq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;

  square_and_sort #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both
  int unsigned idle_mode = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;

  set_item_t  pending_q[$];
  sq_result_t squares_due[$];

  // model of the block: sorted row of squares for the current set
  logic [SquareW-1:0] sorted_row[CAP];
  int                 row_fill = 0;
  bit                 set_dropped = 1'b0;

  function automatic logic [SquareW-1:0] square_of(logic [ValueW-1:0] v);
    logic [16:0] mag;
    logic [33:0] prod;
    mag  = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    prod = mag * mag;
    return prod[SquareW-1:0];
  endfunction

  // takes one input item; on the last item of a set queues the whole sorted row
  task automatic take_set_item(logic [ValueW-1:0] v, logic last);
    logic [SquareW-1:0] sq;
    int                 j;
    sq_result_t         r;
    if (row_fill < CAP) begin
      sq = square_of(v);
      j  = row_fill;
      while (j > 0 && sorted_row[j-1] > sq) begin
        sorted_row[j] = sorted_row[j-1];
        j--;
      end
      sorted_row[j] = sq;
      row_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < row_fill; k++) begin
        r.square   = sorted_row[k];
        r.last     = (k == row_fill - 1);
        r.overflow = set_dropped;
        squares_due = {squares_due, r};
      end
      row_fill    = 0;
      set_dropped = 1'b0;
    end
  endtask

  function automatic bit sender_idles();
    case (idle_mode)
      1: return $urandom_range(99) < 48;
      3: return $urandom_range(99) < 24;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      2: return $urandom_range(99) < 48;
      3: return $urandom_range(99) < 24;
      default: return 1'b0;
    endcase
  endfunction

  // driver: s_tvalid/s_tready sampled before this edge's updates land
  set_item_t next_item;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        take_set_item(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() > 0 && !sender_idles()) begin
          next_item = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_item.value;
          s_tlast  <= next_item.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result item against the oldest queued square
  int unsigned hold_left = 0;
  bit          held[4] = '{default: 1'b0};
  sq_result_t  due;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (squares_due.size() == 0) begin
          $error("result item with none expected: square=%0d", m_tdata[30:0]);
          fail_count++;
        end else begin
          due = squares_due.pop_front();
          if (m_tdata[30:0] !== due.square) begin
            $error("square: expected %0d, got %0d", due.square, m_tdata[30:0]);
            fail_count++;
          end
          if (m_tlast !== due.last) begin
            $error("last_res: expected %0b, got %0b", due.last, m_tlast);
            fail_count++;
          end
          if (m_tuser[0] !== due.overflow) begin
            $error("overflow: expected %0b, got %0b", due.overflow, m_tuser[0]);
            fail_count++;
          end
        end
        // first result of each idling mode: hold off long enough that the
        // sender backs up against a block busy emitting
        if (!held[idle_mode]) begin
          held[idle_mode] = 1'b1;
          hold_left       = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !receiver_stalls();
      end
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [ValueW-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(4))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end else if (pick <= 2) begin
      // narrow range so equal squares show up often
      return $urandom_range(1) ? 16'($urandom_range(15)) : -16'($urandom_range(15));
    end
    return 16'($urandom);
  endfunction

  task automatic queue_set(int n);
    set_item_t it;
    for (int i = 0; i < n; i++) begin
      it.value = random_value();
      it.last  = (i == n - 1);
      pending_q = {pending_q, it};
    end
  endtask

  task automatic queue_values(logic [ValueW-1:0] vals[]);
    set_item_t it;
    foreach (vals[i]) begin
      it.value = vals[i];
      it.last  = (i == vals.size() - 1);
      pending_q = {pending_q, it};
    end
  endtask

  // sizes mostly small; some sets fill the row exactly, some overrun it
  function automatic int random_set_size();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick <= 1) return $urandom_range(CAP + 6, CAP + 1);
    if (pick <= 3) return $urandom_range(CAP, CAP - 4);
    return $urandom_range(12, 1);
  endfunction

  int queued;
  int n;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int mode = 0; mode < 4; mode++) begin
      @(negedge clk);
      idle_mode = mode;
      if (mode == 0) begin
        // extremes, sign pairs and repeated magnitudes
        queue_values('{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001,
                       16'h7FFF, 16'hFFFE, 16'h0002, 16'h4000, 16'hC000});
        // set of one item, the largest square
        queue_values('{16'h8000});
        // equal squares side by side
        queue_values('{16'h0005, 16'hFFFB, 16'h0005, 16'hFFFB, 16'h0003});
      end
      queued = 0;
      while (queued < 88) begin
        n = random_set_size();
        queue_set(n);
        queued += n;
      end
      // drain before switching idling mode
      while (pending_q.size() != 0 || s_tvalid || squares_due.size() != 0)
        @(negedge clk);
    end

    repeat (100) @(negedge clk);
    if (squares_due.size() != 0) begin
      $error("%0d expected result items never arrived", squares_due.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
